### hdl/point_light_vertex_shade_macros.svh
// assertion macros for the point light vertex shader checker
`ifndef POINT_LIGHT_VERTEX_SHADE_MACROS_SVH
`define POINT_LIGHT_VERTEX_SHADE_MACROS_SVH

// same-cycle implication, off during reset
`define PLVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PLVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define PLVS_ASSERT_NXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/plvs_pkg.sv
// shared types and constants of the point light vertex shader
package plvs_pkg;

  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned COLOR_BITS     = 8;
  localparam int unsigned DIV_STEPS      = 8;
  localparam int unsigned APB_AW         = 5;
  localparam int unsigned APB_DW         = 32;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam logic [2:0] REG_LIGHT_X      = 3'd0;
  localparam logic [2:0] REG_LIGHT_Y      = 3'd1;
  localparam logic [2:0] REG_LIGHT_RADIUS = 3'd2;
  localparam logic [2:0] REG_LIGHT_RED    = 3'd3;
  localparam logic [2:0] REG_LIGHT_GREEN  = 3'd4;
  localparam logic [2:0] REG_LIGHT_BLUE   = 3'd5;
  localparam logic [2:0] REG_LIGHT_KIND   = 3'd6;
  localparam logic [2:0] REG_LIGHT_ENABLE = 3'd7;

  typedef struct packed {
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] red;
  } rgb_t;

  typedef struct packed {
    rgb_t color;
    logic kind;
    logic enable;
  } light_mode_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

### hdl/point_light_vertex_shade.sv
// point light vertex shader: register file, front end, queue and shading pipeline
//
// Shades one vertex per word against one point light with linear falloff.
// The light is set over the APB port; the user must see that registers are
// written only while no vertex is in flight, the block does not enforce it.
// Reads return the stored value, pready is always high. Vertex words enter on
// s_axis, results leave on m_axis with the in-range flag on tuser. One word
// is taken per cycle while the output is drained. From input accept to output
// valid a word passes the queue write, squares, sum, one square root stage per
// result bit, the reach test, eight divide stages and the output register.
// When the receiver stalls, the shading pipeline holds as a whole; the front
// end keeps filling the four-word queue, then drops s_axis_tready.
// Reset clears all valid state and loads the light defaults: centre 0,
// radius 0, white, Euclidean, enabled.
module point_light_vertex_shade
  import plvs_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // point_x, point_y, vertex_red, vertex_green, vertex_blue,
  // base_red, base_green, base_blue, zero pad
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  logic [((2*COORD_BITS+6*COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // out_red, out_green, out_blue
  output logic [23:0]                                m_axis_tdata,
  // in_range
  output logic [0:0]                                 m_axis_tuser,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [APB_AW-1:0]                          paddr,
  input  logic [APB_DW-1:0]                          pwdata,
  output logic [APB_DW-1:0]                          prdata,
  output logic                                       pready
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned IN_W = ((2*C+6*COLOR_BITS+7)/8)*8;
  localparam int unsigned QW   = 2*(C-1) + 1 + 6*COLOR_BITS;

  logic [C-1:0] light_x_q, light_y_q;
  logic [C-2:0] light_radius_q;
  light_mode_t  mode_q;
  logic         wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q         <= '0;
      light_y_q         <= '0;
      light_radius_q    <= '0;
      mode_q.color.red   <= 8'hff;
      mode_q.color.green <= 8'hff;
      mode_q.color.blue  <= 8'hff;
      mode_q.kind       <= 1'b0;
      mode_q.enable     <= 1'b1;
    end else if (wr) begin
      case (paddr[4:2])
        REG_LIGHT_X:      light_x_q          <= pwdata[C-1:0];
        REG_LIGHT_Y:      light_y_q          <= pwdata[C-1:0];
        REG_LIGHT_RADIUS: light_radius_q     <= pwdata[C-2:0];
        REG_LIGHT_RED:    mode_q.color.red   <= pwdata[7:0];
        REG_LIGHT_GREEN:  mode_q.color.green <= pwdata[7:0];
        REG_LIGHT_BLUE:   mode_q.color.blue  <= pwdata[7:0];
        REG_LIGHT_KIND:   mode_q.kind        <= pwdata[0];
        REG_LIGHT_ENABLE: mode_q.enable      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_LIGHT_X:      prdata = APB_DW'(light_x_q);
      REG_LIGHT_Y:      prdata = APB_DW'(light_y_q);
      REG_LIGHT_RADIUS: prdata = APB_DW'(light_radius_q);
      REG_LIGHT_RED:    prdata = APB_DW'(mode_q.color.red);
      REG_LIGHT_GREEN:  prdata = APB_DW'(mode_q.color.green);
      REG_LIGHT_BLUE:   prdata = APB_DW'(mode_q.color.blue);
      REG_LIGHT_KIND:   prdata = APB_DW'(mode_q.kind);
      REG_LIGHT_ENABLE: prdata = APB_DW'(mode_q.enable);
      default:          prdata = '0;
    endcase
  end

  logic          push, pop;
  logic [QW-1:0] push_data, head;
  queue_stat_t   stat;

  plvs_front #(
    .COORD_BITS (C),
    .IN_W       (IN_W),
    .QW         (QW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .mode_i         (mode_q),
    .light_x_i      (light_x_q),
    .light_y_i      (light_y_q),
    .light_radius_i (light_radius_q),
    .stat_i         (stat),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  plvs_fifo #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (head),
    .stat_o      (stat)
  );

  plvs_back #(
    .COORD_BITS (C),
    .QW         (QW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .stat_i         (stat),
    .pop_o          (pop),
    .color_i        (mode_q.color),
    .light_radius_i (light_radius_q),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser)
  );

endmodule

### hdl/plvs_front.sv
// front end: takes input words, forms axis offsets and classifies reach
module plvs_front
  import plvs_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned IN_W       = 96,
  parameter int unsigned QW         = 95
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,
  input  light_mode_t           mode_i,
  input  logic [COORD_BITS-1:0] light_x_i,
  input  logic [COORD_BITS-1:0] light_y_i,
  input  logic [COORD_BITS-2:0] light_radius_i,
  input  queue_stat_t           stat_i,
  output logic                  push_o,
  output logic [QW-1:0]         push_data_o
);

  localparam int unsigned C = COORD_BITS;

  logic          v_q, v_d;
  logic [QW-1:0] data_q, data_d;

  logic [C-1:0]   px, py;
  rgb_t           vert, base;
  logic [C:0]     dx, dy, ax, ay;
  logic [C+1:0]   by;
  logic           elig;

  always_comb begin
    px   = s_axis_tdata[C-1:0];
    py   = s_axis_tdata[2*C-1:C];
    vert = s_axis_tdata[2*C+3*COLOR_BITS-1:2*C];
    base = s_axis_tdata[2*C+6*COLOR_BITS-1:2*C+3*COLOR_BITS];
    dx   = {light_x_i[C-1], light_x_i} - {px[C-1], px};
    dy   = {light_y_i[C-1], light_y_i} - {py[C-1], py};
    ax   = dx[C] ? (~dx + 1'b1) : dx;
    ay   = dy[C] ? (~dy + 1'b1) : dy;
    by   = mode_i.kind ? {ay, 1'b0} : {1'b0, ay};
    elig = mode_i.enable && (light_radius_i != '0) &&
           (ax[C:C-1] == '0) && (by[C+1:C-1] == '0);
    data_d = {elig, base, vert, by[C-2:0], ax[C-2:0]};
  end

  assign s_axis_tready = !v_q || !stat_i.full;
  assign push_o        = v_q && !stat_i.full;
  assign push_data_o   = data_q;

  always_comb begin
    v_d = v_q;
    if (s_axis_tready) begin
      v_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      data_q <= data_d;
    end
  end

endmodule

### hdl/plvs_fifo.sv
// short word queue between the front end and the shading pipeline
module plvs_fifo
  import plvs_pkg::*;
#(
  parameter int unsigned W     = 95,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o,
  output queue_stat_t  stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign stat_o.full  = (cnt_q == (PW+1)'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/plvs_back.sv
// back end: squares, pipelined square root, falloff divide and output register
module plvs_back
  import plvs_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned QW         = 95
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [QW-1:0]         head_i,
  input  queue_stat_t           stat_i,
  output logic                  pop_o,
  input  rgb_t                  color_i,
  input  logic [COORD_BITS-2:0] light_radius_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,
  output logic [0:0]            m_axis_tuser
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned AW = C - 1;
  localparam int unsigned NW = 2 * C;
  localparam int unsigned RW = C + 3;
  localparam int unsigned DW = C + 9;
  localparam int unsigned SW = 6 * COLOR_BITS + 1;

  function automatic logic [7:0] chan(rgb_t c, int unsigned k);
    logic [7:0] r;
    case (k)
      0:       r = c.red;
      1:       r = c.green;
      default: r = c.blue;
    endcase
    return r;
  endfunction

  logic en;

  // squares
  logic            m_v_q;
  logic [2*AW-1:0] m_aa_q, m_bb_q;
  logic [SW-1:0]   m_side_q;
  // sum
  logic            s_v_q;
  logic [NW-1:0]   s_n_q;
  logic [SW-1:0]   s_side_q;
  // root steps
  logic            sq_v_q    [C];
  logic [NW-1:0]   sq_n_q    [C];
  logic [RW-1:0]   sq_rem_q  [C];
  logic [C-1:0]    sq_root_q [C];
  logic [SW-1:0]   sq_side_q [C];
  // reach test and products
  logic            l_v_q, l_lit_q;
  logic [DW-1:0]   l_num_q [3];
  logic [SW-2:0]   l_col_q;
  // divide steps
  logic            dv_v_q   [DIV_STEPS];
  logic            dv_lit_q [DIV_STEPS];
  logic [DW-1:0]   dv_rem_q [DIV_STEPS][3];
  logic [7:0]      dv_quo_q [DIV_STEPS][3];
  logic [SW-2:0]   dv_col_q [DIV_STEPS];
  // output
  logic            o_v_q;
  rgb_t            o_data_q;
  logic            o_user_q;

  assign en            = !o_v_q || m_axis_tready;
  assign pop_o         = en && !stat_i.empty;
  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = o_data_q;
  assign m_axis_tuser  = o_user_q;

  // valid bits of the squares, sum, reach test and output stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      s_v_q <= 1'b0;
      l_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= !stat_i.empty;
      s_v_q <= m_v_q;
      l_v_q <= sq_v_q[C-1];
      o_v_q <= dv_v_q[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_aa_q   <= head_i[AW-1:0] * head_i[AW-1:0];
      m_bb_q   <= head_i[2*AW-1:AW] * head_i[2*AW-1:AW];
      m_side_q <= head_i[QW-1:2*AW];
      s_n_q    <= NW'(m_aa_q) + NW'(m_bb_q);
      s_side_q <= m_side_q;
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < C; i++) begin : g_sq
    logic            v_in;
    logic [NW-1:0]   n_in;
    logic [RW-1:0]   rem_in, rem_sh, t, rem_nx;
    logic [C-1:0]    root_in;
    logic [SW-1:0]   side_in;
    logic            ge;

    if (i == 0) begin : g_first
      assign v_in    = s_v_q;
      assign n_in    = s_n_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = s_side_q;
    end else begin : g_next
      assign v_in    = sq_v_q[i-1];
      assign n_in    = sq_n_q[i-1];
      assign rem_in  = sq_rem_q[i-1];
      assign root_in = sq_root_q[i-1];
      assign side_in = sq_side_q[i-1];
    end

    always_comb begin
      rem_sh = {rem_in[RW-3:0], n_in[NW-1-2*i -: 2]};
      t      = RW'({root_in, 2'b01});
      ge     = rem_sh >= t;
      rem_nx = ge ? rem_sh - t : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[i] <= 1'b0;
      end else if (en) begin
        sq_v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_n_q[i]    <= n_in;
        sq_rem_q[i]  <= rem_nx;
        sq_root_q[i] <= {root_in[C-2:0], ge};
        sq_side_q[i] <= side_in;
      end
    end
  end

  // reach test and falloff numerators
  logic [C-1:0]  dlen;
  logic [SW-2:0] l_col_d;
  logic          l_lit_d;
  rgb_t          l_base;
  logic [DW-1:0] l_num_d [3];

  always_comb begin
    dlen    = sq_root_q[C-1];
    l_col_d = sq_side_q[C-1][SW-2:0];
    l_base  = l_col_d[SW-2:3*COLOR_BITS];
    l_lit_d = sq_side_q[C-1][SW-1] && (dlen <= C'(light_radius_i));
    for (int unsigned k = 0; k < 3; k++) begin
      logic [7:0]   lc, bc, d;
      logic [C+7:0] p;
      lc = chan(color_i, k);
      bc = chan(l_base, k);
      d  = (lc >= bc) ? lc - bc : bc - lc;
      p  = dlen * d;
      l_num_d[k] = DW'(p) + DW'(light_radius_i) - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_lit_q <= l_lit_d;
      l_col_q <= l_col_d;
      for (int unsigned k = 0; k < 3; k++) begin
        l_num_q[k] <= l_num_d[k];
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
    logic          v_in, lit_in;
    logic [SW-2:0] col_in;
    logic [DW-1:0] rem_in [3];
    logic [7:0]    quo_in [3];
    logic [DW-1:0] den;

    if (j == 0) begin : g_first
      assign v_in   = l_v_q;
      assign lit_in = l_lit_q;
      assign col_in = l_col_q;
      for (genvar k = 0; k < 3; k++) begin : g_ch
        assign rem_in[k] = l_num_q[k];
        assign quo_in[k] = '0;
      end
    end else begin : g_next
      assign v_in   = dv_v_q[j-1];
      assign lit_in = dv_lit_q[j-1];
      assign col_in = dv_col_q[j-1];
      for (genvar k = 0; k < 3; k++) begin : g_ch
        assign rem_in[k] = dv_rem_q[j-1][k];
        assign quo_in[k] = dv_quo_q[j-1][k];
      end
    end

    assign den = DW'(light_radius_i) << (DIV_STEPS - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j] <= 1'b0;
      end else if (en) begin
        dv_v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_lit_q[j] <= lit_in;
        dv_col_q[j] <= col_in;
        for (int unsigned k = 0; k < 3; k++) begin
          dv_rem_q[j][k] <= (rem_in[k] >= den) ? rem_in[k] - den : rem_in[k];
          dv_quo_q[j][k] <= {quo_in[k][6:0], rem_in[k] >= den};
        end
      end
    end
  end

  // clamp, raise to vertex colour, or pass base
  rgb_t f_vert, f_base, f_out;
  logic [7:0] f_ch [3];

  always_comb begin
    f_vert = dv_col_q[DIV_STEPS-1][3*COLOR_BITS-1:0];
    f_base = dv_col_q[DIV_STEPS-1][SW-2:3*COLOR_BITS];
    for (int unsigned k = 0; k < 3; k++) begin
      logic [7:0] lc, fall, v, vc;
      lc   = chan(color_i, k);
      vc   = chan(f_vert, k);
      fall = dv_quo_q[DIV_STEPS-1][k];
      v    = (fall >= lc) ? 8'd0 : lc - fall;
      f_ch[k] = (v < vc) ? vc : v;
    end
    f_out.red   = f_ch[0];
    f_out.green = f_ch[1];
    f_out.blue  = f_ch[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_data_q <= dv_lit_q[DIV_STEPS-1] ? f_out : f_base;
      o_user_q <= dv_lit_q[DIV_STEPS-1];
    end
  end

endmodule

### hdl/plvs_checker.sv
// port-level checker for the point light vertex shader, bound to the top level
`include "point_light_vertex_shade_macros.svh"

module plvs_checker
  import plvs_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input logic                                           clk_i,
  input logic                                           rst_ni,
  input logic                                           s_axis_tvalid,
  input logic                                           s_axis_tready,
  input logic [((2*COORD_BITS+6*COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  input logic                                           m_axis_tvalid,
  input logic                                           m_axis_tready,
  input logic [23:0]                                    m_axis_tdata,
  input logic [0:0]                                     m_axis_tuser,
  input logic                                           psel,
  input logic                                           penable,
  input logic                                           pwrite,
  input logic [APB_AW-1:0]                              paddr,
  input logic [APB_DW-1:0]                              pwdata,
  input logic [APB_DW-1:0]                              prdata,
  input logic                                           pready
);

  `PLVS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped while stalled")
  `PLVS_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output word changed")
  `PLVS_ASSERT_IMP(a_red_readback, (psel && penable && pwrite && pready && (paddr[4:2] == REG_LIGHT_RED)) ##1 (paddr[4:2] == REG_LIGHT_RED), prdata[7:0] == $past(pwdata[7:0]), "light red readback mismatch")
  `PLVS_ASSERT_NXT_RST(a_reset_idle, !rst_ni, !m_axis_tvalid, "output valid during reset")

endmodule

bind point_light_vertex_shade plvs_checker #(.COORD_BITS(COORD_BITS)) u_plvs_checker (.*);

### tb/sv/point_light_vertex_shade_tb.sv
// self-checking testbench of the point light vertex shader: directed table, then random phases
module point_light_vertex_shade_tb;
  import plvs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = 24;
  localparam int unsigned DW = ((2*CB+6*COLOR_BITS+7)/8)*8;
  localparam int unsigned DRAIN = 60;
  localparam longint HUGE = 64'd1 << (CB-1);

  typedef struct packed {
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    rgb_t          vtx;
    rgb_t          base;
  } vertex_t;

  typedef struct packed {
    rgb_t color;
    logic in_range;
  } shade_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_VTX, ROW_VTX_EXP} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    logic [2:0]    idx;
    logic [31:0]   value;
    vertex_t       vert;
    shade_t        shade;
  } row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [DW-1:0] s_axis_tdata;
  logic [23:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  point_light_vertex_shade uut (.*);

  // light state kept by the predictor
  logic signed [CB-1:0] lt_x, lt_y;
  logic [CB-2:0] lt_rad;
  rgb_t lt_col;
  logic lt_kind, lt_en;

  shade_t shade_q[$];
  int mismatches = 0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic logic [7:0] falloff(logic [7:0] lc, logic [7:0] bc, logic [7:0] vc,
                                         longint unsigned dlen);
    longint unsigned d, fall, v;
    d = (lc >= bc) ? lc - bc : bc - lc;
    fall = (dlen * d + lt_rad - 1) / lt_rad;
    v = (fall >= lc) ? 0 : lc - fall;
    return (v < vc) ? vc : v[7:0];
  endfunction

  function automatic shade_t shade_vertex(vertex_t vt);
    longint sa, sb;
    longint unsigned a, b, dlen;
    shade_t r;
    sa = longint'(lt_x) - longint'($signed(vt.px));
    sb = longint'(lt_y) - longint'($signed(vt.py));
    a = (sa < 0) ? -sa : sa;
    b = (sb < 0) ? -sb : sb;
    if (lt_kind) b <<= 1;
    r.color = vt.base;
    r.in_range = 1'b0;
    if (lt_en && lt_rad != 0 && a < HUGE && b < HUGE) begin
      dlen = root_floor(a * a + b * b);
      if (dlen <= lt_rad) begin
        r.in_range = 1'b1;
        r.color.red = falloff(lt_col.red, vt.base.red, vt.vtx.red, dlen);
        r.color.green = falloff(lt_col.green, vt.base.green, vt.vtx.green, dlen);
        r.color.blue = falloff(lt_col.blue, vt.base.blue, vt.vtx.blue, dlen);
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    case (idx)
      REG_LIGHT_X: lt_x = val[CB-1:0];
      REG_LIGHT_Y: lt_y = val[CB-1:0];
      REG_LIGHT_RADIUS: lt_rad = val[CB-2:0];
      REG_LIGHT_RED: lt_col.red = val[7:0];
      REG_LIGHT_GREEN: lt_col.green = val[7:0];
      REG_LIGHT_BLUE: lt_col.blue = val[7:0];
      REG_LIGHT_KIND: lt_kind = val[0];
      default: lt_en = val[0];
    endcase
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // offers one word and returns once it is taken
  task automatic send_vertex(vertex_t vt, bit typed, shade_t want);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {vt.base.blue, vt.base.green, vt.base.red,
                     vt.vtx.blue, vt.vtx.green, vt.vtx.red, vt.py, vt.px};
    do @(posedge clk_i); while (!s_axis_tready);
    shade_q.push_back(typed ? want : shade_vertex(vt));
  endtask

  function automatic vertex_t rand_vertex();
    vertex_t vt;
    int unsigned span;
    vt.vtx = rgb_t'($urandom());
    vt.base = rgb_t'($urandom());
    span = (lt_rad < 4) ? 8 : lt_rad + lt_rad / 4;
    if ($urandom_range(0, 4) != 0) begin
      vt.px = CB'(lt_x + $signed($urandom_range(0, 2*span)) - $signed(span));
      vt.py = CB'(lt_y + $signed($urandom_range(0, 2*span)) - $signed(span));
    end else begin
      vt.px = CB'($urandom());
      vt.py = CB'($urandom());
    end
    return vt;
  endfunction

  task automatic rand_light(bit wide);
    write_reg(REG_LIGHT_X, wide ? 32'h800000 : $urandom());
    write_reg(REG_LIGHT_Y, wide ? 32'h7FFFFF : $urandom());
    write_reg(REG_LIGHT_RADIUS, wide ? 32'h7FFFFF : $urandom_range(1, 1 << $urandom_range(1, 22)));
    write_reg(REG_LIGHT_RED, $urandom());
    write_reg(REG_LIGHT_GREEN, $urandom());
    write_reg(REG_LIGHT_BLUE, $urandom());
    write_reg(REG_LIGHT_KIND, $urandom());
    write_reg(REG_LIGHT_ENABLE, $urandom_range(0, 7) != 0);
  endtask

  // receiver side, with one long hold on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      shade_t got, want;
      got = {m_axis_tdata[23:16], m_axis_tdata[15:8], m_axis_tdata[7:0], m_axis_tuser[0]};
      if (shade_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = shade_q.pop_front();
        if (got.color.red !== want.color.red || got.color.green !== want.color.green ||
            got.color.blue !== want.color.blue || got.in_range !== want.in_range) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch expected %h actual %h", want, got);
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  row_t rows[$];

  initial begin
    vertex_t vt;
    rgb_t white, black;
    white = '1;
    black = '0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0; s_axis_tdata <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    lt_x = 0; lt_y = 0; lt_rad = 0; lt_col = white; lt_kind = 0; lt_en = 1;
    // radius zero after reset lights nothing
    rows.push_back({ROW_VTX_EXP, 3'd0, 32'd0, {24'd0, 24'd0, 24'h102030, 24'h405060},
                    {24'h405060, 1'b0}});
    rows.push_back({ROW_CFG, REG_LIGHT_RADIUS, 32'h100, vertex_t'(0), shade_t'(0)});
    rows.push_back({ROW_VTX_EXP, 3'd0, 32'd0, {24'd0, 24'd0, 24'h010203, 24'h000000},
                    {white, 1'b1}});
    rows.push_back({ROW_VTX, 3'd0, 32'd0, {24'h000100, 24'd0, 24'h112233, black}, shade_t'(0)});
    rows.push_back({ROW_VTX_EXP, 3'd0, 32'd0, {24'h000101, 24'd0, 24'hFFFFFF, 24'h0A0B0C},
                    {24'h0A0B0C, 1'b0}});
    rows.push_back({ROW_VTX_EXP, 3'd0, 32'd0, {24'h800000, 24'h800000, black, 24'h123456},
                    {24'h123456, 1'b0}});
    rows.push_back({ROW_CFG, REG_LIGHT_RADIUS, 32'h7FFFFF, vertex_t'(0), shade_t'(0)});
    rows.push_back({ROW_CFG, REG_LIGHT_X, 32'h7FFFFF, vertex_t'(0), shade_t'(0)});
    rows.push_back({ROW_VTX_EXP, 3'd0, 32'd0, {24'h800000, 24'd0, black, 24'h654321},
                    {24'h654321, 1'b0}});
    rows.push_back({ROW_VTX, 3'd0, 32'd0, {24'd0, 24'd0, black, black}, shade_t'(0)});
    rows.push_back({ROW_VTX, 3'd0, 32'd0, {24'h7FFFFF, 24'h7FFFFF, black, white}, shade_t'(0)});
    rows.push_back({ROW_CFG, REG_LIGHT_Y, 32'h800000, vertex_t'(0), shade_t'(0)});
    rows.push_back({ROW_CFG, REG_LIGHT_KIND, 32'd1, vertex_t'(0), shade_t'(0)});
    rows.push_back({ROW_VTX, 3'd0, 32'd0, {24'h7FFFFF, 24'hC00000, black, black}, shade_t'(0)});
    rows.push_back({ROW_VTX_EXP, 3'd0, 32'd0, {24'h7FFFFF, 24'h000000, black, 24'h777777},
                    {24'h777777, 1'b0}});
    rows.push_back({ROW_CFG, REG_LIGHT_KIND, 32'd0, vertex_t'(0), shade_t'(0)});
    rows.push_back({ROW_CFG, REG_LIGHT_RED, 32'd0, vertex_t'(0), shade_t'(0)});
    rows.push_back({ROW_CFG, REG_LIGHT_GREEN, 32'd128, vertex_t'(0), shade_t'(0)});
    rows.push_back({ROW_CFG, REG_LIGHT_BLUE, 32'd255, vertex_t'(0), shade_t'(0)});
    rows.push_back({ROW_VTX, 3'd0, 32'd0, {24'h7FFFFF, 24'hFFFFFF, 24'h050505, white},
                    shade_t'(0)});
    rows.push_back({ROW_CFG, REG_LIGHT_ENABLE, 32'd0, vertex_t'(0), shade_t'(0)});
    rows.push_back({ROW_VTX_EXP, 3'd0, 32'd0, {24'h7FFFFF, 24'h800000, white, 24'h3C2D1E},
                    {24'h3C2D1E, 1'b0}});
    rows.push_back({ROW_CFG, REG_LIGHT_ENABLE, 32'd1, vertex_t'(0), shade_t'(0)});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(rows[i].idx, rows[i].value);
      end else begin
        send_vertex(rows[i].vert, rows[i].kind == ROW_VTX_EXP, rows[i].shade);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      rand_light(ph == 1);
      if (ph == 5) idle_en = 1'b0;
      for (int n = 0; n < 215; n++) begin
        if (ph == 2 && n == 20) hold_req = 1'b1;
        if (ph == 3 && n == 100) begin
          s_axis_tvalid <= 1'b0;
          while (shade_q.size() != 0) @(posedge clk_i);
        end
        vt = rand_vertex();
        send_vertex(vt, 1'b0, shade_t'(0));
      end
    end
    s_axis_tvalid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
